// ===== hw/rtl/ntsd_pkg.sv =====
// shared constants, types and segment code functions for the segment row driver
package ntsd_pkg;

    // row geometry
    localparam int DIGITS    = 8;
    localparam int POS_W     = 3;
    localparam int SEG_W     = 7;
    localparam int VALUE_W   = 32;
    localparam int NIB_W     = 4;
    localparam int BCD_CELLS = 8;
    localparam int SHIFT_CNT_W = 5;
    localparam int LEN_W     = 4;

    // decimal range limit
    localparam logic [VALUE_W-1:0] DEC_LIMIT = 32'd99999999;

    // configuration register indexes
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_START_POS = 2'd0;
    localparam logic [1:0] REG_FIELD_LEN = 2'd1;
    localparam logic [1:0] REG_FILL_MODE = 2'd2;
    localparam logic [1:0] REG_RADIX_HEX = 2'd3;

    // raw character bytes: digits 0-9 then a-f
    localparam logic [7:0] CHAR_CODES [16] = '{
        8'hf5, 8'h60, 8'hd3, 8'hf2, 8'h66, 8'hb6, 8'hb7, 8'he0,
        8'hf7, 8'hf6, 8'he7, 8'h37, 8'h95, 8'h73, 8'h97, 8'h87
    };
    localparam logic [7:0] CHAR_MINUS = 8'h02;
    localparam logic [7:0] CHAR_BLANK = 8'h00;

    // control of one conversion cell
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // fold a raw code byte into the seven segment lines, dropping bit 3
    function automatic logic [SEG_W-1:0] pack_code(input logic [7:0] b);
        return {b[7:4], b[2:0]};
    endfunction

    // segment pattern of one nibble
    function automatic logic [SEG_W-1:0] nibble_seg(input logic [NIB_W-1:0] d);
        return pack_code(CHAR_CODES[d]);
    endfunction

endpackage

// ===== hw/rtl/ntsd_in_if.sv =====
// input request channel carrying the value to show
interface ntsd_in_if;
    import ntsd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== hw/rtl/ntsd_out_if.sv =====
// output request channel carrying one segment position per request
interface ntsd_out_if;
    import ntsd_pkg::*;

    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   position;
    logic [SEG_W-1:0]   segments;
    logic               overflow;
    logic               last_result;

    modport source (output valid, output position, output segments,
                    output overflow, output last_result, input ready);
    modport sink   (input valid, input position, input segments,
                    input overflow, input last_result, output ready);
endinterface

// ===== hw/rtl/number_to_segment_display.sv =====
// top level: number to eight-position segment row driver
//
// Usage: configure through the APB port while idle (start_pos at 0x0, field_len
// at 0x4, fill_mode at 0x8, radix_hex at 0xc; pready is always high). Each
// request on data_in carries one value. The block redraws its stored row and
// then sends eight requests on data_out, positions 0 to 7 in order, the last
// one flagged by last_result; overflow is repeated on all eight.
// Sequence: decimal values are accepted, shifted serially through the row of
// BCD cells, written into the row image, then sent as eight output
// requests. Hex values skip the chain shift and load their nibbles into the
// cells directly. One value is handled at a time; data_in.ready is high only
// between values.
// Stalls: a low data_out.ready holds the current position until taken.
// Reset: the row clears to all segments off, registers return to start_pos 0,
// field_len 8, fill_mode 1, radix_hex 0, data_out goes quiet and data_in.ready is high.
module number_to_segment_display (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ntsd_pkg::ADDR_W-1:0]     paddr,
    input  logic [ntsd_pkg::DATA_W-1:0]     pwdata,
    output logic [ntsd_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    ntsd_in_if.sink                         data_in,
    ntsd_out_if.source                      data_out
);
    import ntsd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_WRITE,
        ST_EMIT
    } state_t;

    // configuration registers
    logic [POS_W-1:0]   start_pos_reg;
    logic [LEN_W-1:0]   field_len_reg;
    logic               fill_mode_reg;
    logic               radix_hex_reg;

    // control and datapath registers
    state_t                 state_reg;
    logic [SHIFT_CNT_W-1:0] cnt_reg;
    logic [VALUE_W-1:0]     mag_reg;
    logic                   ovf_reg;
    logic                   neg_reg;
    logic                   hex_reg;
    logic [SEG_W-1:0]       image_reg [DIGITS];

    // output registers
    logic                   out_valid_reg;
    logic [POS_W-1:0]       position_reg;
    logic [SEG_W-1:0]       segments_reg;
    logic                   overflow_reg;
    logic                   last_reg;

    logic                   in_accept;
    logic                   cfg_write;
    logic [1:0]             reg_index;
    logic [VALUE_W-1:0]     raw;
    logic [VALUE_W-1:0]     mag;
    cell_ctrl_t             cell_ctrl;
    logic [NIB_W-1:0]       digits [BCD_CELLS];
    logic [BCD_CELLS-1:0]   carries;
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       nd;
    logic [LEN_W-1:0]       ndig;
    logic [POS_W-1:0]       anchor;
    logic [SEG_W-1:0]       img_next [DIGITS];
    logic [POS_W-1:0]       pos_inc;

    // apb decode
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_index)
            REG_START_POS: prdata = DATA_W'(start_pos_reg);
            REG_FIELD_LEN: prdata = DATA_W'(field_len_reg);
            REG_FILL_MODE: prdata = DATA_W'(fill_mode_reg);
            REG_RADIX_HEX: prdata = DATA_W'(radix_hex_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg <= '0;
            field_len_reg <= LEN_W'(8);
            fill_mode_reg <= 1'b1;
            radix_hex_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_START_POS: start_pos_reg <= pwdata[POS_W-1:0];
                REG_FIELD_LEN: field_len_reg <= pwdata[LEN_W-1:0];
                REG_FILL_MODE: fill_mode_reg <= pwdata[0];
                REG_RADIX_HEX: radix_hex_reg <= pwdata[0];
                default:       start_pos_reg <= start_pos_reg;
            endcase
        end
    end

    // input side: magnitude of the request value
    assign data_in.ready = (state_reg == ST_IDLE);
    assign in_accept     = data_in.valid && data_in.ready;
    assign raw           = VALUE_W'(data_in.value);
    assign mag           = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

    assign cell_ctrl.load  = in_accept;
    assign cell_ctrl.shift = (state_reg == ST_CONVERT);

    // chain of conversion cells, lowest digit fed from the magnitude msb
    for (genvar i = 0; i < BCD_CELLS; i++)
    begin : g_cell
        ntsd_bcd_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .load_digit (radix_hex_reg ? raw[NIB_W*i +: NIB_W] : NIB_W'(0)),
            .shift_in   ((i == 0) ? mag_reg[VALUE_W-1] : carries[(i == 0) ? 0 : i-1]),
            .digit      (digits[i]),
            .carry_out  (carries[i])
        );
    end

    // digit count and field geometry
    always_comb
    begin
        len    = (field_len_reg > LEN_W'(8)) ? LEN_W'(8) : field_len_reg;
        anchor = POS_W'(DIGITS - 1) - start_pos_reg;
        nd     = LEN_W'(1);
        for (int i = 1; i < BCD_CELLS; i++)
        begin
            if (digits[i] != '0)
            begin
                nd = LEN_W'(i + 1);
            end
        end
        ndig = (hex_reg || fill_mode_reg) ? nd : len;
    end

    // new row image: blank the field, then draw digits and decimal sign unless overflow
    always_comb
    begin
        for (int p = 0; p < DIGITS; p++)
        begin
            logic [POS_W-1:0] k;
            logic [LEN_W-1:0] kw;
            k  = anchor - POS_W'(p);
            kw = LEN_W'(k);
            img_next[p] = image_reg[p];
            if (POS_W'(p) <= anchor)
            begin
                if (kw < len)
                begin
                    img_next[p] = pack_code(CHAR_BLANK);
                end
                if (hex_reg)
                begin
                    if (kw < nd)
                    begin
                        img_next[p] = nibble_seg(digits[k]);
                    end
                end
                else if (!ovf_reg)
                begin
                    if (kw < ndig)
                    begin
                        img_next[p] = nibble_seg(digits[k]);
                    end
                    else if (kw == ndig)
                    begin
                        img_next[p] = neg_reg ? pack_code(CHAR_MINUS)
                                              : pack_code(CHAR_BLANK);
                    end
                end
            end
        end
    end

    assign pos_inc = position_reg + POS_W'(1);

    // sequencer, row image and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mag_reg       <= '0;
            ovf_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            hex_reg       <= 1'b0;
            for (int p = 0; p < DIGITS; p++)
            begin
                image_reg[p] <= '0;
            end
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
            segments_reg  <= '0;
            overflow_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        mag_reg <= mag;
                        neg_reg <= raw[VALUE_W-1];
                        hex_reg <= radix_hex_reg;
                        ovf_reg <= !radix_hex_reg && (mag > DEC_LIMIT);
                        cnt_reg <= '0;
                        state_reg <= radix_hex_reg ? ST_WRITE : ST_CONVERT;
                    end
                end
                ST_CONVERT:
                begin
                    mag_reg <= {mag_reg[VALUE_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + SHIFT_CNT_W'(1);
                    if (cnt_reg == SHIFT_CNT_W'(VALUE_W - 1))
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    for (int p = 0; p < DIGITS; p++)
                    begin
                        image_reg[p] <= img_next[p];
                    end
                    out_valid_reg <= 1'b1;
                    position_reg  <= '0;
                    segments_reg  <= img_next[0];
                    overflow_reg  <= ovf_reg;
                    last_reg      <= 1'b0;
                    state_reg     <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (data_out.ready)
                    begin
                        if (position_reg == POS_W'(DIGITS - 1))
                        begin
                            out_valid_reg <= 1'b0;
                            last_reg      <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            position_reg <= pos_inc;
                            segments_reg <= image_reg[pos_inc];
                            last_reg     <= (pos_inc == POS_W'(DIGITS - 1));
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign data_out.valid       = out_valid_reg;
    assign data_out.position    = position_reg;
    assign data_out.segments    = segments_reg;
    assign data_out.overflow    = overflow_reg;
    assign data_out.last_result = last_reg;
endmodule

// ===== hw/rtl/ntsd_bcd_cell.sv =====
// one decimal digit cell of the shift-and-add-3 conversion chain
module ntsd_bcd_cell (
    input  logic                        clk,
    input  ntsd_pkg::cell_ctrl_t        ctrl,
    input  logic [ntsd_pkg::NIB_W-1:0]  load_digit,
    input  logic                        shift_in,
    output logic [ntsd_pkg::NIB_W-1:0]  digit,
    output logic                        carry_out
);
    import ntsd_pkg::*;

    logic [NIB_W-1:0] digit_reg;
    logic [NIB_W-1:0] adj;

    // add 3 when the digit would pass 9 after doubling
    always_comb
    begin
        adj = (digit_reg >= NIB_W'(5)) ? digit_reg + NIB_W'(3) : digit_reg;
    end

    assign carry_out = adj[NIB_W-1];
    assign digit     = digit_reg;

    // load or shift one bit in from the lower neighbor
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            digit_reg <= load_digit;
        end
        else if (ctrl.shift)
        begin
            digit_reg <= {adj[NIB_W-2:0], shift_in};
        end
    end
endmodule
